@@ src/fcrm_pkg.sv @@
// Shared types and constants for the counting resource manager.
`default_nettype none
package fcrm_pkg;

    // Parameter defaults
    localparam int NUM_RESOURCES_DEF = 4;
    localparam int QUEUE_DEPTH_DEF   = 8;

    // Fixed field widths
    localparam int NUM_CAP_REGS = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CAP_W        = 8;
    localparam int CMD_W        = 2;
    localparam int TASK_W       = 8;
    localparam int RSEL_W       = 2;
    localparam int UNITS_W      = 8;
    localparam int KIND_W       = 3;
    localparam int ENTRY_W      = TASK_W + UNITS_W;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 8'd1;

    // Commands carried on the input tuser
    localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        EV_GRANTED        = 3'd0,
        EV_SUSPENDED      = 3'd1,
        EV_QUEUE_FULL     = 3'd2,
        EV_RELEASE_ACK    = 3'd3,
        EV_WAITER_GRANTED = 3'd4,
        EV_CLEARED        = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE      = 2'd0,
        ST_EXEC      = 2'd1,
        ST_REL_CHECK = 2'd2,
        ST_REL_WAIT  = 2'd3
    } state_t;

    // One result word
    typedef struct packed {
        event_t             kind;
        logic [TASK_W-1:0]  task_id;
        logic [RSEL_W-1:0]  rsel;
        logic [UNITS_W-1:0] units;
        logic [CAP_W-1:0]   free_units;
    } result_t;

    // Write side of the wait-entry memory
    typedef struct packed {
        logic               en;
        logic [TASK_W-1:0]  task_id;
        logic [UNITS_W-1:0] units;
    } wr_req_t;

endpackage
`default_nettype wire

@@ src/fcrm_wait_mem.sv @@
// Wait-entry memory: one write port, one read port with registered data.
`default_nettype none
module fcrm_wait_mem import fcrm_pkg::*; #(
    parameter int DEPTH  = NUM_RESOURCES_DEF * QUEUE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(NUM_RESOURCES_DEF * QUEUE_DEPTH_DEF)
) (
    input  wire logic               aclk,
    input  wire wr_req_t            wr_req,
    input  wire logic [ADDR_W-1:0]  wr_addr,
    input  wire logic [ADDR_W-1:0]  rd_addr,
    output logic [ENTRY_W-1:0]      rd_data
);

    logic [ENTRY_W-1:0] mem_reg [DEPTH];

    // Write a queued task
    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            mem_reg[wr_addr] <= {wr_req.task_id, wr_req.units};
        end
    end

    // Read every cycle, data in the next cycle
    always_ff @(posedge aclk) begin
        rd_data <= mem_reg[rd_addr];
    end

endmodule
`default_nettype wire

@@ src/fcrm_top_unused_guard.sv @@
// Registered view of the configured capacities, indexed by resource select.
`default_nettype none
module fcrm_cap_regs import fcrm_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [CAP_W-1:0]     cfg_data,
    input  wire logic [RSEL_W-1:0]    rsel,
    output logic [CAP_W-1:0]          cap
);

    logic [CAP_W-1:0] cap_reg [NUM_CAP_REGS];

    // Capture capacity writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CAP_REGS; i++) begin
                cap_reg[i] <= CAP_RESET;
            end
        end else if (cfg_we) begin
            cap_reg[cfg_idx] <= cfg_data;
        end
    end

    assign cap = cap_reg[rsel];

endmodule
`default_nettype wire

@@ src/fcounting_resource_manager_top.sv @@
// Top level: command sequencer, per-resource counters and result register.
`default_nettype none
// A request, clear or rejected command is accepted and then executed to give its
// result word; execution waits while a held result word is not taken. A release
// gives its acknowledge and then one more result word for each waiter it grants:
// every queue head is fetched through the single read port of the wait-entry
// memory, whose data arrives in the cycle after the address. An item is accepted
// only once the previous one is finished; a held result word does not block
// acceptance. The wait-entry memory needs no clearing pass after reset.
module fcfs_counting_resource_manager import fcrm_pkg::*; #(
    parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [CAP_W-1:0]     cfg_data,
    // Command stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // task_id[7:0], resource_id[9:8], units[17:10]
    input  wire logic [CMD_W-1:0]     s_tuser,  // cmd[1:0]
    // Event stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,  // out_task[7:0], out_resource[9:8],
                                                // out_units[17:10], free_units[25:18]
    output logic [KIND_W-1:0]         m_tuser,  // event_kind[2:0]
    output logic                      m_tlast
);

    localparam int RIDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int HEAD_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_RESOURCES * QUEUE_DEPTH;
    localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [HEAD_W:0]   QD_SUM   = (HEAD_W + 1)'(QUEUE_DEPTH);
    localparam logic [HEAD_W-1:0] HEAD_MAX = HEAD_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] QD_FILL  = FILL_W'(QUEUE_DEPTH);

    state_t state_reg, state_next;

    // Latched command
    logic [CMD_W-1:0]   cmd_reg;
    logic [TASK_W-1:0]  task_reg;
    logic [RSEL_W-1:0]  rsel_reg;
    logic [UNITS_W-1:0] units_reg;

    // Per-resource counters
    logic [CAP_W-1:0]  free_reg [NUM_RESOURCES];
    logic [CAP_W-1:0]  free_next [NUM_RESOURCES];
    logic [HEAD_W-1:0] head_reg [NUM_RESOURCES];
    logic [HEAD_W-1:0] head_next [NUM_RESOURCES];
    logic [FILL_W-1:0] fill_reg [NUM_RESOURCES];
    logic [FILL_W-1:0] fill_next [NUM_RESOURCES];

    // Pending release events and the output register
    result_t pend_reg, pend_next;
    result_t m_res_reg;
    logic    m_last_reg;
    logic    m_valid_reg;

    // Datapath
    logic [RIDX_W-1:0]  res_idx;
    logic [RIDX_W-1:0]  cfg_ridx;
    logic               res_ok;
    logic [CAP_W-1:0]   cur_free;
    logic [HEAD_W-1:0]  cur_head;
    logic [FILL_W-1:0]  cur_fill;
    logic [CAP_W-1:0]   cur_cap;
    logic [CAP_W:0]     rel_sum;
    logic [CAP_W-1:0]   rel_free;
    logic [HEAD_W:0]    tail_sum;
    logic [HEAD_W-1:0]  tail;
    logic [ADDR_W-1:0]  base_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic [TASK_W-1:0]  head_task;
    logic [UNITS_W-1:0] head_units;
    logic               can_grant;
    logic               can_emit;
    logic               emit;
    logic               emit_last;
    result_t            emit_res;
    wr_req_t            wr_req;
    logic               s_accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign can_emit = !m_valid_reg || m_tready;

    assign res_idx  = RIDX_W'(rsel_reg);
    assign cfg_ridx = RIDX_W'(cfg_idx);
    assign res_ok   = (int'(rsel_reg) < NUM_RESOURCES) && (int'(rsel_reg) < NUM_CAP_REGS);
    assign cur_free = free_reg[res_idx];
    assign cur_head = head_reg[res_idx];
    assign cur_fill = fill_reg[res_idx];

    fcrm_cap_regs u_cap (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .rsel     (rsel_reg),
        .cap      (cur_cap)
    );

    // Release: saturate at capacity
    assign rel_sum  = {1'b0, cur_free} + {1'b0, units_reg};
    assign rel_free = (rel_sum > {1'b0, cur_cap}) ? cur_cap : rel_sum[CAP_W-1:0];

    // Tail slot of the current queue
    assign tail_sum = {1'b0, cur_head} + (HEAD_W + 1)'(cur_fill);
    assign tail     = (tail_sum >= QD_SUM) ? HEAD_W'(tail_sum - QD_SUM) : tail_sum[HEAD_W-1:0];

    // Memory addressing: head for reads, tail for writes
    assign base_addr = ADDR_W'(int'(res_idx) * QUEUE_DEPTH);
    assign rd_addr   = base_addr + ADDR_W'(cur_head);
    assign wr_addr   = base_addr + ADDR_W'(tail);

    fcrm_wait_mem #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_wait_mem (
        .aclk    (aclk),
        .wr_req  (wr_req),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign head_task  = rd_data[ENTRY_W-1:UNITS_W];
    assign head_units = rd_data[UNITS_W-1:0];
    assign can_grant  = (cur_free != '0) && (cur_fill != '0) && (head_units <= cur_free);

    // Sequencer: next state, counter updates and result selection
    always_comb begin
        state_next = state_reg;
        free_next  = free_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        pend_next  = pend_reg;
        emit       = 1'b0;
        emit_last  = 1'b1;
        emit_res   = pend_reg;
        wr_req.en      = 1'b0;
        wr_req.task_id = task_reg;
        wr_req.units   = units_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (cmd_reg)
                    CMD_CLEAR: begin
                        if (can_emit) begin
                            emit     = 1'b1;
                            emit_res = '{kind: EV_CLEARED, task_id: '0, rsel: '0,
                                         units: '0, free_units: '0};
                            for (int i = 0; i < NUM_RESOURCES; i++) begin
                                head_next[i] = '0;
                                fill_next[i] = '0;
                            end
                            state_next = ST_IDLE;
                        end
                    end
                    CMD_REQUEST, CMD_RELEASE: begin
                        if (!res_ok) begin
                            if (can_emit) begin
                                emit     = 1'b1;
                                emit_res = '{kind: EV_QUEUE_FULL, task_id: task_reg,
                                             rsel: rsel_reg, units: units_reg,
                                             free_units: '0};
                                state_next = ST_IDLE;
                            end
                        end else if (cmd_reg == CMD_RELEASE) begin
                            // Return units, then look at the queue head
                            free_next[res_idx] = rel_free;
                            pend_next = '{kind: EV_RELEASE_ACK, task_id: task_reg,
                                          rsel: rsel_reg, units: units_reg,
                                          free_units: rel_free};
                            state_next = ST_REL_CHECK;
                        end else if (can_emit) begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                            if (cur_fill == '0 && cur_free >= units_reg) begin
                                free_next[res_idx] = cur_free - units_reg;
                                emit_res = '{kind: EV_GRANTED, task_id: task_reg,
                                             rsel: rsel_reg, units: units_reg,
                                             free_units: cur_free - units_reg};
                            end else if (cur_fill < QD_FILL) begin
                                wr_req.en          = 1'b1;
                                fill_next[res_idx] = cur_fill + FILL_W'(1);
                                emit_res = '{kind: EV_SUSPENDED, task_id: task_reg,
                                             rsel: rsel_reg, units: units_reg,
                                             free_units: cur_free};
                            end else begin
                                emit_res = '{kind: EV_QUEUE_FULL, task_id: task_reg,
                                             rsel: rsel_reg, units: units_reg,
                                             free_units: cur_free};
                            end
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_REL_CHECK: begin
                // Send the held event; grant the head if it fits
                if (can_emit) begin
                    emit      = 1'b1;
                    emit_res  = pend_reg;
                    emit_last = !can_grant;
                    if (can_grant) begin
                        free_next[res_idx] = cur_free - head_units;
                        head_next[res_idx] = (cur_head == HEAD_MAX) ? '0
                                             : cur_head + HEAD_W'(1);
                        fill_next[res_idx] = cur_fill - FILL_W'(1);
                        pend_next = '{kind: EV_WAITER_GRANTED, task_id: head_task,
                                      rsel: rsel_reg, units: head_units,
                                      free_units: cur_free - head_units};
                        state_next = ST_REL_WAIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REL_WAIT: begin
                // Wait for the new head to be read
                state_next = ST_REL_CHECK;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Clamp the free count to a newly written capacity
        if (cfg_we && int'(cfg_idx) < NUM_RESOURCES) begin
            if (free_next[cfg_ridx] > cfg_data) begin
                free_next[cfg_ridx] = cfg_data;
            end
        end
    end

    // Control state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < NUM_RESOURCES; i++) begin
                free_reg[i] <= (i < NUM_CAP_REGS) ? CAP_RESET : '0;
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            free_reg  <= free_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
        end
    end

    // Latch the accepted word and the pending event
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg   <= s_tuser;
            task_reg  <= s_tdata[TASK_W-1:0];
            rsel_reg  <= s_tdata[TASK_W +: RSEL_W];
            units_reg <= s_tdata[TASK_W + RSEL_W +: UNITS_W];
        end
        pend_reg <= pend_next;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_res_reg  <= emit_res;
            m_last_reg <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {(M_TDATA_W - CAP_W - UNITS_W - RSEL_W - TASK_W)'(0),
                       m_res_reg.free_units, m_res_reg.units,
                       m_res_reg.rsel, m_res_reg.task_id};

    // A new result never overwrites one that is still held
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten");

    // Queue fill stays within the depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res_ok |-> (cur_fill <= QD_FILL))
        else $error("queue fill beyond depth");

    // Free count never exceeds the capacity
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res_ok |-> (cur_free <= cur_cap))
        else $error("free count above capacity");

    // A granted waiter leaves the queue one entry shorter
    a_grant_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REL_WAIT) |-> (cur_fill == $past(cur_fill) - FILL_W'(1)))
        else $error("waiter grant did not pop the queue");

endmodule
`default_nettype wire
